>>> rtl/ipv6_address_text_parser_assert.svh
// Assertion macros shared by the parser modules.
`ifndef IPV6_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define IPV6_ADDRESS_TEXT_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define V6TP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define V6TP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define V6TP_ASSERT(lbl, clk, rst_n, prop, msg)
`define V6TP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/v6tp_pkg.sv
`default_nettype none
package v6tp_pkg;

    localparam int ADDR_BYTES       = 16;
    localparam int OCTET_MAX        = 255;
    localparam int GROUP_DIGITS_MAX = 4;
    localparam int OCTET_DIGITS_MAX = 3;
    localparam int QUEUE_DEPTH      = 2;

    // one character after classification
    typedef struct packed {
        logic       term;   // zero byte, end of text
        logic       colon;
        logic       dot;
        logic       hex;    // 0-9, a-f, A-F
        logic       dec;    // 0-9
        logic [3:0] nib;    // digit value when hex
    } t_tok;

endpackage
`default_nettype wire

>>> rtl/v6tp_if.sv
`default_nettype none
interface v6tp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface v6tp_res_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output ok, output addr_high, output addr_low, input ready);
    modport sink (input valid, input ok, input addr_high, input addr_low, output ready);
endinterface
`default_nettype wire

>>> rtl/v6tp_front.sv
`default_nettype none
module v6tp_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    v6tp_char_if.sink       i_ch_if,
    output v6tp_pkg::t_tok  o_tok,
    output logic            o_tok_vld,
    input  wire             i_tok_rdy
);
    import v6tp_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    logic r_vld;
    t_tok r_tok;
    t_tok n_tok;
    logic take;
    logic is_dec;
    logic is_low;
    logic is_up;
    logic [7:0] nib_wide;

    assign i_ch_if.ready = !r_vld || i_tok_rdy;
    assign take          = i_ch_if.valid && i_ch_if.ready;

    always_comb begin
        is_dec = (i_ch_if.ch >= CH_ZERO) && (i_ch_if.ch <= CH_NINE);
        is_low = (i_ch_if.ch >= CH_LA) && (i_ch_if.ch <= CH_LF);
        is_up  = (i_ch_if.ch >= CH_UA) && (i_ch_if.ch <= CH_UF);
        priority if (is_low) begin
            nib_wide = i_ch_if.ch - CH_LA + HEX_TEN;
        end else if (is_up) begin
            nib_wide = i_ch_if.ch - CH_UA + HEX_TEN;
        end else begin
            nib_wide = i_ch_if.ch - CH_ZERO;
        end
        n_tok.term  = (i_ch_if.ch == CH_NUL);
        n_tok.colon = (i_ch_if.ch == CH_COLON);
        n_tok.dot   = (i_ch_if.ch == CH_DOT);
        n_tok.dec   = is_dec;
        n_tok.hex   = is_dec || is_low || is_up;
        n_tok.nib   = nib_wide[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_tok_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_vld = r_vld;

endmodule
`default_nettype wire

>>> rtl/v6tp_fifo.sv
`default_nettype none
`include "ipv6_address_text_parser_assert.svh"
module v6tp_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_vld,
    input  v6tp_pkg::t_tok  i_push_tok,
    output logic            o_push_rdy,
    output logic            o_pop_vld,
    output v6tp_pkg::t_tok  o_pop_tok,
    input  wire             i_pop_rdy
);
    import v6tp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_tok             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_rdy = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign o_pop_tok  = r_mem[r_rd];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

    `V6TP_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `V6TP_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_cnt == '0) |-> (r_wr == r_rd), "empty queue ptrs differ")
    `V6TP_ASSERT(a_push_grows, i_clk, i_rst_n, (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1), "push lost")

endmodule
`default_nettype wire

>>> rtl/v6tp_back.sv
`default_nettype none
`include "ipv6_address_text_parser_assert.svh"
module v6tp_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_tok_vld,
    input  v6tp_pkg::t_tok  i_tok,
    output logic            o_tok_rdy,
    v6tp_res_if.source      o_res_if
);
    import v6tp_pkg::*;

    localparam logic [2:0] PH_START        = 3'd0;
    localparam logic [2:0] PH_LEAD_COLON   = 3'd1;
    localparam logic [2:0] PH_IN_GROUP     = 3'd2;
    localparam logic [2:0] PH_AFTER_COLON  = 3'd3;
    localparam logic [2:0] PH_AFTER_DCOLON = 3'd4;

    localparam logic [5:0] BYTES6 = 6'(ADDR_BYTES);
    localparam logic [4:0] BYTES5 = 5'(ADDR_BYTES);
    localparam logic [9:0] OCT10  = 10'(OCTET_MAX);

    logic [2:0]   r_phase, n_phase;
    logic [127:0] r_head, n_head;
    logic [127:0] r_tail, n_tail;
    logic [4:0]   r_hcnt, n_hcnt;
    logic [4:0]   r_tcnt, n_tcnt;
    logic         r_comp, n_comp;
    logic [15:0]  r_gval, n_gval;
    logic [2:0]   r_gdig, n_gdig;
    logic         r_gdec, n_gdec;
    logic         r_dot, n_dot;
    logic [1:0]   r_oidx, n_oidx;
    logic [9:0]   r_oval, n_oval;
    logic [1:0]   r_odig, n_odig;
    logic [31:0]  r_v4, n_v4;
    logic         r_fail, n_fail;

    logic         r_out_vld;
    logic         r_ok;
    logic [63:0]  r_hi;
    logic [63:0]  r_lo;

    logic         out_free;
    logic         tok_take;
    logic [4:0]   cnt;
    logic [2:0]   lane;
    logic [2:0]   lane_nx;
    logic [127:0] g_head;
    logic [127:0] d_head;
    logic [31:0]  v4_full;
    logic [9:0]   dval;
    logic         lead_zero;
    logic [9:0]   oval_nx;
    logic         do_digit;

    logic         fin_ok;
    logic [127:0] fin_head;
    logic [127:0] fin_tail;
    logic [4:0]   fin_hc;
    logic [4:0]   fin_tc;
    logic [5:0]   fin_sum;
    logic [127:0] fin_addr;

    assign out_free  = !r_out_vld || o_res_if.ready;
    assign o_tok_rdy = !i_tok.term || out_free;
    assign tok_take  = i_tok_vld && o_tok_rdy;

    assign cnt     = r_comp ? r_tcnt : r_hcnt;
    assign lane    = cnt[3:1];
    assign lane_nx = lane + 3'd1;
    assign v4_full = {r_v4[31:8], r_oval[7:0]};
    assign oval_nx = 10'(r_oval * 10'd10) + {6'd0, i_tok.nib};

    // head holds groups at their byte position; tail shifts in from the right
    always_comb begin
        g_head = r_head;
        d_head = r_head;
        for (int k = 0; k < 8; k++) begin
            if (lane == 3'(k)) begin
                g_head[127 - 16*k -: 16] = r_gval;
                d_head[127 - 16*k -: 16] = v4_full[31:16];
            end
            if (lane_nx == 3'(k)) begin
                d_head[127 - 16*k -: 16] = v4_full[15:0];
            end
        end
    end

    // current group read back as a decimal octet
    always_comb begin
        unique case (r_gdig)
            3'd1: dval = {6'd0, r_gval[3:0]};
            3'd2: dval = 10'({6'd0, r_gval[7:4]} * 10'd10) + {6'd0, r_gval[3:0]};
            3'd3: dval = 10'({6'd0, r_gval[11:8]} * 10'd100)
                       + 10'({6'd0, r_gval[7:4]} * 10'd10) + {6'd0, r_gval[3:0]};
            default: dval = 10'd0;
        endcase
        unique case (r_gdig)
            3'd2:    lead_zero = (r_gval[7:4] == 4'd0);
            3'd3:    lead_zero = (r_gval[11:8] == 4'd0);
            default: lead_zero = 1'b0;
        endcase
    end

    // close the text on the terminator
    always_comb begin
        fin_ok   = !r_fail;
        fin_head = r_head;
        fin_tail = r_tail;
        fin_hc   = r_hcnt;
        fin_tc   = r_tcnt;
        if (r_phase == PH_IN_GROUP) begin
            if (r_dot) begin
                if (r_oidx != 2'd3 || r_odig == 2'd0 || r_oval > OCT10) begin
                    fin_ok = 1'b0;
                end else if (r_comp) begin
                    fin_tail = {r_tail[95:0], v4_full};
                    fin_tc   = r_tcnt + 5'd4;
                end else begin
                    fin_head = d_head;
                    fin_hc   = r_hcnt + 5'd4;
                end
            end else if (({1'b0, cnt} + 6'd2) > BYTES6) begin
                fin_ok = 1'b0;
            end else if (r_comp) begin
                fin_tail = {r_tail[111:0], r_gval};
                fin_tc   = r_tcnt + 5'd2;
            end else begin
                fin_head = g_head;
                fin_hc   = r_hcnt + 5'd2;
            end
        end else if (r_phase != PH_AFTER_DCOLON) begin
            fin_ok = 1'b0;
        end
        fin_sum = {1'b0, fin_hc} + {1'b0, fin_tc};
        if (r_comp) begin
            fin_ok = fin_ok && (fin_sum < BYTES6);
        end else begin
            fin_ok = fin_ok && (fin_hc == BYTES5);
        end
        fin_addr = fin_ok ? (fin_head | fin_tail) : 128'd0;
    end

    always_comb begin
        n_phase  = r_phase;
        n_head   = r_head;
        n_tail   = r_tail;
        n_hcnt   = r_hcnt;
        n_tcnt   = r_tcnt;
        n_comp   = r_comp;
        n_gval   = r_gval;
        n_gdig   = r_gdig;
        n_gdec   = r_gdec;
        n_dot    = r_dot;
        n_oidx   = r_oidx;
        n_oval   = r_oval;
        n_odig   = r_odig;
        n_v4     = r_v4;
        n_fail   = r_fail;
        do_digit = 1'b0;
        if (tok_take && i_tok.term) begin
            n_phase = PH_START;
            n_head  = '0;
            n_tail  = '0;
            n_hcnt  = '0;
            n_tcnt  = '0;
            n_comp  = 1'b0;
            n_gval  = '0;
            n_gdig  = '0;
            n_gdec  = 1'b1;
            n_dot   = 1'b0;
            n_oidx  = '0;
            n_oval  = '0;
            n_odig  = '0;
            n_v4    = '0;
            n_fail  = 1'b0;
        end else if (tok_take && !r_fail) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_tok.colon) begin
                        n_phase = PH_LEAD_COLON;
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                PH_LEAD_COLON: begin
                    if (i_tok.colon) begin
                        n_comp  = 1'b1;
                        n_phase = PH_AFTER_DCOLON;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                PH_AFTER_COLON: begin
                    if (i_tok.colon) begin
                        if (r_comp) begin
                            n_fail = 1'b1;
                        end else begin
                            n_comp  = 1'b1;
                            n_phase = PH_AFTER_DCOLON;
                        end
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                PH_AFTER_DCOLON: begin
                    do_digit = 1'b1;
                end
                PH_IN_GROUP: begin
                    if (r_dot) begin
                        if (i_tok.dec) begin
                            if (r_odig == 2'(OCTET_DIGITS_MAX)
                                    || (r_odig != 2'd0 && r_oval == 10'd0)) begin
                                n_fail = 1'b1;
                            end else begin
                                n_oval = oval_nx;
                                n_odig = r_odig + 2'd1;
                            end
                        end else if (i_tok.dot) begin
                            if (r_oidx == 2'd3 || r_odig == 2'd0 || r_oval > OCT10) begin
                                n_fail = 1'b1;
                            end else begin
                                n_v4[31 - 8*r_oidx -: 8] = r_oval[7:0];
                                n_oval = '0;
                                n_odig = '0;
                                n_oidx = r_oidx + 2'd1;
                            end
                        end else begin
                            n_fail = 1'b1;
                        end
                    end else if (i_tok.colon) begin
                        n_phase = PH_AFTER_COLON;
                        if (({1'b0, cnt} + 6'd2) > BYTES6) begin
                            n_fail = 1'b1;
                        end else begin
                            if (r_comp) begin
                                n_tail = {r_tail[111:0], r_gval};
                                n_tcnt = r_tcnt + 5'd2;
                            end else begin
                                n_head = g_head;
                                n_hcnt = r_hcnt + 5'd2;
                            end
                            n_gval = '0;
                            n_gdig = '0;
                            n_gdec = 1'b1;
                        end
                    end else if (i_tok.dot) begin
                        if (!r_gdec || r_gdig == 3'd0 || r_gdig > 3'(OCTET_DIGITS_MAX)
                                || lead_zero || dval > OCT10
                                || ({1'b0, cnt} + 6'd4) > BYTES6) begin
                            n_fail = 1'b1;
                        end else begin
                            n_v4   = {dval[7:0], 24'd0};
                            n_dot  = 1'b1;
                            n_oidx = 2'd1;
                            n_oval = '0;
                            n_odig = '0;
                        end
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                default: n_fail = 1'b1;
            endcase
            if (do_digit) begin
                if (!i_tok.hex || r_gdig >= 3'(GROUP_DIGITS_MAX)) begin
                    n_fail = 1'b1;
                end else begin
                    n_gval  = {r_gval[11:0], i_tok.nib};
                    n_gdig  = r_gdig + 3'd1;
                    n_phase = PH_IN_GROUP;
                    if (!i_tok.dec) begin
                        n_gdec = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_head  <= '0;
            r_tail  <= '0;
            r_hcnt  <= '0;
            r_tcnt  <= '0;
            r_comp  <= 1'b0;
            r_gval  <= '0;
            r_gdig  <= '0;
            r_gdec  <= 1'b1;
            r_dot   <= 1'b0;
            r_oidx  <= '0;
            r_oval  <= '0;
            r_odig  <= '0;
            r_v4    <= '0;
            r_fail  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_hcnt  <= n_hcnt;
            r_tcnt  <= n_tcnt;
            r_comp  <= n_comp;
            r_gval  <= n_gval;
            r_gdig  <= n_gdig;
            r_gdec  <= n_gdec;
            r_dot   <= n_dot;
            r_oidx  <= n_oidx;
            r_oval  <= n_oval;
            r_odig  <= n_odig;
            r_v4    <= n_v4;
            r_fail  <= n_fail;
        end
    end

    // result register: load on the terminator, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (tok_take && i_tok.term) begin
            r_out_vld <= 1'b1;
        end else if (o_res_if.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_take && i_tok.term) begin
            r_ok <= fin_ok;
            r_hi <= fin_addr[127:64];
            r_lo <= fin_addr[63:0];
        end
    end

    assign o_res_if.valid     = r_out_vld;
    assign o_res_if.ok        = r_ok;
    assign o_res_if.addr_high = r_hi;
    assign o_res_if.addr_low  = r_lo;

    `V6TP_ASSERT(a_even_counts, i_clk, i_rst_n, (r_hcnt[0] == 1'b0) && (r_tcnt[0] == 1'b0), "odd byte count")
    `V6TP_ASSERT(a_tail_needs_comp, i_clk, i_rst_n, !r_comp |-> (r_tcnt == 5'd0), "tail bytes without compression")
    `V6TP_ASSERT(a_dot_in_group, i_clk, i_rst_n, r_dot |-> (r_phase == PH_IN_GROUP), "dotted tail outside group")
    `V6TP_ASSERT(a_clear_after_end, i_clk, i_rst_n, (tok_take && i_tok.term) |=> (r_phase == PH_START && !r_fail && r_hcnt == 5'd0 && r_out_vld), "state not cleared after terminator")

endmodule
`default_nettype wire

>>> rtl/ipv6_address_text_parser.sv
`default_nettype none
// IPv6 address text parser. Feed the text one character per item on i_ch_if, ending each
// address with a zero byte; that terminator yields one result on o_res_if with ok set and
// the 128-bit address split into addr_high (bytes 0-7) and addr_low (bytes 8-15), or ok
// clear and a zero address if the text was rejected (bad group, misplaced or repeated
// "::", malformed dotted IPv4 tail, too many or too few groups, any suffix). All other
// characters yield nothing. One character is taken every cycle unless the queue backs up: a
// classify register feeds a two-entry queue, and the back end updates the parse state of
// one character per cycle while any are queued. A terminator only waits when the previous
// result still sits unread in the output register, which each accepted terminator loads.
module ipv6_address_text_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    v6tp_char_if.sink    i_ch_if,
    v6tp_res_if.source   o_res_if
);
    import v6tp_pkg::*;

    t_tok front_tok;
    logic front_vld;
    logic front_rdy;
    t_tok back_tok;
    logic back_vld;
    logic back_rdy;

    v6tp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ch_if   (i_ch_if),
        .o_tok     (front_tok),
        .o_tok_vld (front_vld),
        .i_tok_rdy (front_rdy)
    );

    v6tp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .i_push_tok (front_tok),
        .o_push_rdy (front_rdy),
        .o_pop_vld  (back_vld),
        .o_pop_tok  (back_tok),
        .i_pop_rdy  (back_rdy)
    );

    v6tp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok_vld (back_vld),
        .i_tok     (back_tok),
        .o_tok_rdy (back_rdy),
        .o_res_if  (o_res_if)
    );

endmodule
`default_nettype wire
